// ===== hdl/ida_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ida_pkg
// Shared constants, chain record type and GF(2^8)/GF(2^16) multiply.
// ----------------------------------------------------------------------------
package ida_pkg;

    localparam int MAX_SHARES = 16;
    localparam int MAX_BLOCK  = 16;
    localparam int ROW_W      = $clog2(MAX_SHARES);
    localparam int COL_W      = $clog2(MAX_BLOCK);
    localparam int SYM_W      = 16;
    localparam int CNT_W      = 5;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SYMBOL = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam logic [1:0] REG_FIELD_MODE   = 2'd0;
    localparam logic [1:0] REG_SHARE_COUNT  = 2'd1;
    localparam logic [1:0] REG_BLOCK_LENGTH = 2'd2;

    localparam logic [16:0] POLY16 = 17'h1100B;
    localparam logic [8:0]  POLY8  = 9'h171;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic             last;
        logic [SYM_W-1:0] acc;
    } chain_t;

    // x^k reduced by the field polynomial, constant arguments only
    function automatic logic [15:0] xpow_mod(input int k, input logic wide);
        logic [16:0] v;
        v = 17'd1;
        for (int i = 0; i < k; i++)
        begin
            v = v << 1;
            if (wide && v[16])
                v = v ^ POLY16;
            if (!wide && v[8])
                v = v ^ {8'h00, POLY8};
        end
        return v[15:0];
    endfunction

    function automatic logic [15:0] gf_mul(input logic [15:0] a, input logic [15:0] b,
                                           input logic wide);
        logic [15:0] am;
        logic [15:0] bm;
        logic [30:0] p;
        logic [15:0] r;
        am = wide ? a : {8'h00, a[7:0]};
        bm = wide ? b : {8'h00, b[7:0]};
        p  = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (bm[i])
                p = p ^ ({15'd0, am} << i);
        end
        if (wide)
        begin
            r = p[15:0];
            for (int k = 16; k < 31; k++)
            begin
                if (p[k])
                    r = r ^ xpow_mod(k, 1'b1);
            end
        end
        else
        begin
            r = {8'h00, p[7:0]};
            for (int k = 8; k < 15; k++)
            begin
                if (p[k])
                    r = r ^ xpow_mod(k, 1'b0);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/ida_share_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ida_share_encoder
// Information dispersal encoder over GF(2^8) or GF(2^16), one share per row.
// ----------------------------------------------------------------------------
// Loads and symbols are accepted only while idle. When a block completes (or
// a flush finds waiting symbols) the input stalls while the N share rows
// enter a chain of 16 column cells, one row per cycle unless the output is
// held off; each cell within the block length adds its column's product, and
// once the last share leaves the chain the block takes input again.
module ida_share_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // coef_row, coef_col, coef_value, symbol
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // share_index, share_value, zero pad
    output logic        m_tlast
);
    import ida_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic             mode_reg;
    logic [CNT_W-1:0] share_count_reg;
    logic [CNT_W-1:0] block_length_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             out_valid_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [SYM_W-1:0] out_acc_reg;
    logic             out_last_reg;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] m_eff;
    logic [ROW_W-1:0] n_last;
    logic             adv;
    logic             in_xfer;
    logic [1:0]       op;
    logic [CNT_W-1:0] fill_inc;
    logic             emit_start;
    logic             done;
    logic [SYM_W-1:0] sym_masked;
    chain_t           link [MAX_BLOCK+1];

    always_comb
    begin
        if (share_count_reg == '0)
            n_eff = CNT_W'(1);
        else if (share_count_reg > CNT_W'(MAX_SHARES))
            n_eff = CNT_W'(MAX_SHARES);
        else
            n_eff = share_count_reg;
        if (block_length_reg == '0)
            m_eff = CNT_W'(1);
        else if (block_length_reg > CNT_W'(MAX_BLOCK))
            m_eff = CNT_W'(MAX_BLOCK);
        else
            m_eff = block_length_reg;
    end

    assign n_last     = ROW_W'(n_eff - CNT_W'(1));
    assign adv        = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_xfer    = s_tvalid && s_tready;
    assign op         = s_tuser;
    assign fill_inc   = fill_reg + CNT_W'(1);
    assign emit_start = in_xfer && (((op == OP_SYMBOL) && (fill_inc >= m_eff))
                                    || ((op == OP_FLUSH) && (fill_reg != '0)));
    assign done       = adv && link[MAX_BLOCK].valid && link[MAX_BLOCK].last;
    assign sym_masked = mode_reg ? s_tdata[39:24] : {8'h00, s_tdata[31:24]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= 1'b0;
            share_count_reg  <= CNT_W'(5);
            block_length_reg <= CNT_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FIELD_MODE:   mode_reg         <= cfg_data[0];
                REG_SHARE_COUNT:  share_count_reg  <= cfg_data;
                REG_BLOCK_LENGTH: block_length_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        fill_next  = fill_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (op == OP_SYMBOL))
                    fill_next = fill_inc;
                if (emit_start)
                begin
                    state_next = ST_ISSUE;
                    row_next   = '0;
                end
            end
            ST_ISSUE:
            begin
                if (adv)
                begin
                    row_next = row_reg + ROW_W'(1);
                    if (row_reg == n_last)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                    fill_next  = '0;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            fill_reg  <= fill_next;
        end
    end

    always_comb
    begin
        link[0].valid = (state_reg == ST_ISSUE);
        link[0].row   = row_reg;
        link[0].last  = (row_reg == n_last);
        link[0].acc   = '0;
    end

    for (genvar c = 0; c < MAX_BLOCK; c++)
    begin : g_cell
        ida_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .wide       (mode_reg),
            .col_on     (CNT_W'(c) < m_eff),
            .load_we    (in_xfer && (op == OP_LOAD) && (s_tdata[7:4] == COL_W'(c))),
            .load_row   (s_tdata[3:0]),
            .load_value (s_tdata[23:8]),
            .sym_we     (in_xfer && (op == OP_SYMBOL) && (fill_reg == CNT_W'(c))),
            .sym_value  (sym_masked),
            .sym_clr    (done),
            .chain_in   (link[c]),
            .chain_out  (link[c+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= link[MAX_BLOCK].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_row_reg  <= link[MAX_BLOCK].row;
            out_acc_reg  <= link[MAX_BLOCK].acc;
            out_last_reg <= link[MAX_BLOCK].last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_acc_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input accepted while shares are in flight");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_BLOCK))
        else $error("fill count past block buffer");

    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[3:0] == n_last))
        else $error("last share not on final row");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && done) |=> (state_reg == ST_IDLE && fill_reg == '0))
        else $error("block not retired after last share");

endmodule

// ===== hdl/ida_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ida_cell
// One column cell: holds a symbol and its coefficient column, adds its
// product into the partial share passing down the chain.
// ----------------------------------------------------------------------------
module ida_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      wide,
    input  logic                      col_on,
    input  logic                      load_we,
    input  logic [ida_pkg::ROW_W-1:0] load_row,
    input  logic [ida_pkg::SYM_W-1:0] load_value,
    input  logic                      sym_we,
    input  logic [ida_pkg::SYM_W-1:0] sym_value,
    input  logic                      sym_clr,
    input  ida_pkg::chain_t           chain_in,
    output ida_pkg::chain_t           chain_out
);
    import ida_pkg::*;

    logic [SYM_W-1:0] coef_reg [MAX_SHARES];
    logic [SYM_W-1:0] sym_reg;
    chain_t           link_reg;
    chain_t           link_next;

    always_ff @(posedge clk)
    begin
        if (load_we)
            coef_reg[load_row] <= load_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sym_reg <= '0;
        else if (sym_clr)
            sym_reg <= '0;
        else if (sym_we)
            sym_reg <= sym_value;
    end

    always_comb
    begin
        link_next = chain_in;
        if (col_on)
            link_next.acc = chain_in.acc ^ gf_mul(coef_reg[chain_in.row], sym_reg, wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            link_reg <= '0;
        else if (adv)
            link_reg <= link_next;
    end

    assign chain_out = link_reg;

endmodule

// ===== dv/ida_share_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ida_share_encoder_tb
// Stream test of the information dispersal share encoder.
// ----------------------------------------------------------------------------
// Coefficients are loaded, symbols are streamed in and every share that comes
// out is checked against a local GF(2^8)/GF(2^16) dot product computed from a
// shadow copy of the coefficients, block buffer and registers. Both stream
// sides idle at random, with a stretch of full-rate traffic.
// ----------------------------------------------------------------------------
module ida_share_encoder_tb;
    import ida_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [3:0]  index;
        logic [15:0] value;
        logic        last;
    } share_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [4:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    logic [15:0] coef_shadow [0:MAX_SHARES*MAX_BLOCK-1];
    logic [15:0] block_shadow [0:MAX_BLOCK-1];
    int          fill_shadow;
    logic        mode_shadow;
    logic [4:0]  shares_shadow;
    logic [4:0]  length_shadow;
    share_t      share_queue [$];
    int          errors;
    int          stall_cycles;
    bit          idle_on;

    ida_share_encoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    function automatic logic [15:0] field_mul(logic [15:0] a, logic [15:0] b, logic wide);
        logic [16:0] x;
        logic [15:0] acc;
        int          bits;
        bits = wide ? 16 : 8;
        x    = wide ? {1'b0, a} : {9'd0, a[7:0]};
        acc  = '0;
        for (int i = 0; i < bits; i++)
        begin
            if (b[i])
                acc = acc ^ x[15:0];
            x = x << 1;
            if (wide && x[16])
                x = x ^ 17'h1100B;
            if (!wide && x[8])
                x = x ^ 17'h00171;
        end
        return wide ? acc : {8'h00, acc[7:0]};
    endfunction

    function automatic int clamp16(logic [4:0] v);
        if (v == 0)
            return 1;
        return (v > 16) ? 16 : int'(v);
    endfunction

    function automatic void predict_shares();
        int          n;
        int          m;
        logic [15:0] acc;
        n = clamp16(shares_shadow);
        m = clamp16(length_shadow);
        for (int r = 0; r < n; r++)
        begin
            acc = '0;
            for (int c = 0; c < m; c++)
                acc = acc ^ field_mul(coef_shadow[r*MAX_BLOCK+c], block_shadow[c], mode_shadow);
            share_queue.push_back('{index: r[3:0], value: acc, last: (r == n - 1)});
        end
        for (int c = 0; c < MAX_BLOCK; c++)
            block_shadow[c] = '0;
        fill_shadow = 0;
    endfunction

    function automatic void apply_item(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                                       logic [15:0] cv, logic [15:0] sym);
        if (op == OP_LOAD)
            coef_shadow[row*MAX_BLOCK+col] = cv;
        else if (op == OP_SYMBOL)
        begin
            if (fill_shadow < MAX_BLOCK)
                block_shadow[fill_shadow] = mode_shadow ? sym : {8'h00, sym[7:0]};
            fill_shadow++;
            if (fill_shadow >= clamp16(length_shadow))
                predict_shares();
        end
        else if (op == OP_FLUSH && fill_shadow != 0)
            predict_shares();
    endfunction

    task automatic send_item(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                             logic [15:0] cv, logic [15:0] sym);
        while (idle_on && $urandom_range(99) < 22)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {sym, cv, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_item(op, row, col, cv, sym);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (share_queue.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        drain();
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FIELD_MODE)
            mode_shadow = val[0];
        else if (idx == REG_SHARE_COUNT)
            shares_shadow = val;
        else if (idx == REG_BLOCK_LENGTH)
            length_shadow = val;
    endtask

    // rows 0..7 by columns 0..3, all of column 0 and all of row 0
    task automatic load_coefficients();
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 4; c++)
                send_item(OP_LOAD, r[3:0], c[3:0], 16'($urandom), 16'($urandom));
        for (int r = 8; r < MAX_SHARES; r++)
            send_item(OP_LOAD, r[3:0], 4'h0, 16'($urandom), 16'($urandom));
        for (int c = 4; c < MAX_BLOCK; c++)
            send_item(OP_LOAD, 4'h0, c[3:0], 16'($urandom), 16'($urandom));
    endtask

    task automatic test_directed();
        idle_on = 1'b0;
        load_coefficients();
        send_item(OP_LOAD, 4'd15, 4'd15, 16'hFFFF, 16'h0000);
        send_item(OP_LOAD, 4'd0, 4'd0, 16'h0000, 16'hFFFF);
        send_item(OP_SYMBOL, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF);
        send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'h0000);
        send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'h8080);
        send_item(OP_FLUSH, 4'h0, 4'h0, 16'h0000, 16'h0000);
        send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'h00FF);
        send_item(OP_FLUSH, 4'h0, 4'h0, 16'h0000, 16'h0000);
        send_item(OP_UNUSED, 4'h3, 4'h3, 16'h1234, 16'h5678);
        send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'h1234);
        write_reg(REG_FIELD_MODE, 5'd1);
        send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'hFFFF);
        send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'h8001);
        send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'h4321);
        send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'h0001);
        write_reg(REG_BLOCK_LENGTH, 5'd1);
        send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'hFFFF);
        write_reg(REG_SHARE_COUNT, 5'd16);
        send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'h9ABC);
        write_reg(REG_SHARE_COUNT, 5'd1);
        write_reg(REG_BLOCK_LENGTH, 5'd16);
        for (int i = 0; i < 16; i++)
            send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'($urandom));
        for (int i = 0; i < 5; i++)
            send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'($urandom));
        write_reg(REG_BLOCK_LENGTH, 5'd3);
        send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'h00AA);
        write_reg(REG_FIELD_MODE, 5'd0);
        send_item(OP_FLUSH, 4'h0, 4'h0, 16'h0000, 16'h0000);
    endtask

    task automatic test_register_edges();
        write_reg(REG_SHARE_COUNT, 5'd0);
        write_reg(REG_BLOCK_LENGTH, 5'd0);
        send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'h00C3);
        write_reg(REG_SHARE_COUNT, 5'd31);
        write_reg(REG_BLOCK_LENGTH, 5'd1);
        send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'h005A);
        write_reg(REG_SHARE_COUNT, 5'd1);
        write_reg(REG_BLOCK_LENGTH, 5'd31);
        for (int i = 0; i < 16; i++)
            send_item(OP_SYMBOL, 4'h0, 4'h0, 16'h0000, 16'($urandom));
    endtask

    task automatic test_random(int count, logic wide);
        logic [1:0] op;
        int         pick;
        write_reg(REG_FIELD_MODE, {4'd0, wide});
        write_reg(REG_SHARE_COUNT, 5'($urandom_range(8, 1)));
        write_reg(REG_BLOCK_LENGTH, 5'($urandom_range(4, 1)));
        for (int i = 0; i < count; i++)
        begin
            idle_on = (i < count / 3) ? 1'b0 : 1'b1;
            pick = $urandom_range(99);
            op = (pick < 70) ? OP_SYMBOL : (pick < 85) ? OP_LOAD :
                 (pick < 95) ? OP_FLUSH : OP_UNUSED;
            send_item(op, 4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
        end
        send_item(OP_FLUSH, 4'h0, 4'h0, 16'h0000, 16'h0000);
    endtask

    always @(posedge clk)
    begin
        m_tready <= !idle_on || ($urandom_range(99) >= 22);
    end

    always @(posedge clk)
    begin
        share_t got;
        share_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{index: m_tdata[3:0], value: m_tdata[19:4], last: m_tlast};
            if (share_queue.size() == 0)
            begin
                $error("unexpected share transfer index %0d value %h", got.index, got.value);
                errors++;
            end
            else
            begin
                want = share_queue.pop_front();
                if (got.index !== want.index)
                begin
                    $error("share_index expected %0d actual %0d", want.index, got.index);
                    errors++;
                end
                if (got.value !== want.value)
                begin
                    $error("share_value expected %h actual %h", want.value, got.value);
                    errors++;
                end
                if (got.last !== want.last)
                begin
                    $error("last expected %0d actual %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 5000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        errors        = 0;
        stall_cycles  = 0;
        idle_on       = 1'b0;
        fill_shadow   = 0;
        mode_shadow   = 1'b0;
        shares_shadow = 5'd5;
        length_shadow = 5'd3;
        for (int c = 0; c < MAX_BLOCK; c++)
            block_shadow[c] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_edges();
        test_random(50, 1'b0);
        test_random(50, 1'b1);
        drain();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
